// ===== src/mcfd_pkg.sv =====
// Shared constants and types of the multi-channel frame deframer.
package mcfd_pkg;

	localparam int unsigned CHAN_W      = 2;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned PAYLOAD_LEN = 7;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned LANE_W      = 3;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] FTR_BYTE = 8'hAA;

	// Frame position codes: hunting, payload slots 1 to 7, footer slot.
	localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
	localparam logic [POS_W-1:0] POS_LAST   = 4'd7;
	localparam logic [POS_W-1:0] POS_FOOTER = 4'd8;

	// Payload byte positions that carry meaning.
	localparam int unsigned PL_BALL_DIR  = 0;
	localparam int unsigned PL_BALL_DIST = 1;
	localparam int unsigned PL_GOAL_DIR  = 2;
	localparam int unsigned PL_GOAL_DIST = 3;
	localparam int unsigned PL_WALL      = 4;
	localparam int unsigned PL_FLAGS     = 5;
	localparam int unsigned PL_PROX      = 6;

	localparam int unsigned FLAG_YELLOW = 0;
	localparam int unsigned FLAG_FRONT  = 1;

	typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] payload_t;

	typedef struct packed {
		logic     done;
		payload_t payload;
	} frame_status_t;

endpackage

// ===== src/mcfd_framer.sv =====
// Per-channel header/payload/footer framer with its payload store.
module mcfd_framer
	import mcfd_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              step,
	input  logic [CHAN_W-1:0] channel,
	input  logic [BYTE_W-1:0] rx_byte,
	output frame_status_t     status
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [POS_W-1:0] pos_q     [CHANNELS];
	payload_t         payload_q [CHANNELS];

	logic [CH_W-1:0]   idx;
	logic              ch_ok;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  pos_next;
	logic              storing;
	logic [LANE_W-1:0] lane;

	assign idx   = CH_W'(channel);
	assign ch_ok = (32'(channel) < 32'(CHANNELS));
	assign pos   = pos_q[idx];
	assign lane  = LANE_W'(pos - 4'd1);

	always_comb begin
		pos_next = pos;
		storing  = 1'b0;
		status.done    = 1'b0;
		status.payload = payload_q[idx];
		priority if (pos == POS_HUNT) begin
			if (rx_byte == HDR_BYTE) begin
				pos_next = 4'd1;
			end
		end else if (pos <= POS_LAST) begin
			storing  = 1'b1;
			pos_next = pos + 4'd1;
		end else begin
			// Footer slot: the frame ends here whatever the byte is.
			pos_next    = POS_HUNT;
			status.done = item_valid && ch_ok && (rx_byte == FTR_BYTE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= POS_HUNT;
			end
		end else if (step && ch_ok) begin
			pos_q[idx] <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ch_ok && storing) begin
			payload_q[idx][lane] <= rx_byte;
		end
	end

endmodule

// ===== src/mcfd_front_filter.sv =====
// Per-channel all-of-last-N filter on the goal-front flag.
module mcfd_front_filter
	import mcfd_pkg::*;
#(
	parameter int CHANNELS     = 4,
	parameter int FILTER_DEPTH = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write,
	input  logic [CHAN_W-1:0] channel,
	input  logic              front,
	output logic              all_set
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

	logic [FILTER_DEPTH-1:0] hist_q [CHANNELS];
	logic [PTR_W-1:0]        ptr_q  [CHANNELS];

	logic [CH_W-1:0]         idx;
	logic [PTR_W-1:0]        ptr;
	logic [PTR_W-1:0]        ptr_next;
	logic [FILTER_DEPTH-1:0] row_new;

	assign idx = CH_W'(channel);

	always_comb begin
		ptr = ptr_q[idx];
		if (32'(ptr) >= 32'(FILTER_DEPTH)) begin
			ptr = '0;
		end
		ptr_next = (32'(ptr) == 32'(FILTER_DEPTH - 1)) ? '0 : ptr + 1'b1;
		row_new      = hist_q[idx];
		row_new[ptr] = front;
		all_set      = &row_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				hist_q[i] <= '0;
				ptr_q[i]  <= '0;
			end
		end else if (write) begin
			hist_q[idx] <= row_new;
			ptr_q[idx]  <= ptr_next;
		end
	end

endmodule

// ===== src/multi_channel_frame_deframer_core.sv =====
// Top level of the multi-channel frame deframer.
//
// The slave stream carries one received byte per word, tagged in s_tuser with
// the link it came from. Each link runs its own framer: it hunts for header
// 0xFF, stores seven payload bytes, and checks for footer 0xAA. A good frame
// produces one word on the master stream; a bad footer drops the frame
// silently. Words for links beyond CHANNELS are consumed and ignored.
// Every accepted word enters an input register; the framer, the goal-colour
// steering and the goal-front filter work on it there combinationally, and a
// finished frame is written into the output register, which drives m_tvalid.
// One word per cycle is taken in steady state, as long as no stall holds the
// input register.
// When the receiver stalls, a finished result waits in the output register
// while the input register keeps taking words; only a second result that
// meets a full output register holds the input register, and s_tready drops.
// Reset clears every framer to hunting, the filter histories to zero and both
// valid flags; the payload store is not cleared and needs no clearing.
module multi_channel_frame_deframer_core
	import mcfd_pkg::*;
#(
	parameter int CHANNELS     = 4,
	parameter int FILTER_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] heading_byte
	input  logic [1:0]  s_tuser,   // [1:0] channel
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] ball_direction, [15:8] ball_distance, [23:16] wall_distance,
	// [31:24] proximity_value, [39:32] yellow_direction, [47:40] yellow_distance,
	// [55:48] blue_direction, [63:56] blue_distance, [64] front_filtered,
	// [72:65] reply_byte, [79:73] zero
	output logic [79:0] m_tdata,
	output logic [1:0]  m_tuser    // [1:0] frame_channel
);

	// Input register.
	logic              valid_s1;
	logic [CHAN_W-1:0] channel_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic [BYTE_W-1:0] heading_s1;

	// Output register.
	logic              out_valid_q;
	logic [79:0]       out_data_q;
	logic [CHAN_W-1:0] out_chan_q;

	frame_status_t status;
	logic          front_all;
	logic          out_free;
	logic          adv_s1;
	logic          yellow;
	logic [79:0]   result;

	// The input word leaves its register when it makes no result or when
	// the output register can take the result.
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!status.done || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			channel_s1 <= s_tuser;
			rx_byte_s1 <= s_tdata[7:0];
			heading_s1 <= s_tdata[15:8];
		end
	end

	mcfd_framer #(
		.CHANNELS (CHANNELS)
	) u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.step       (adv_s1),
		.channel    (channel_s1),
		.rx_byte    (rx_byte_s1),
		.status     (status)
	);

	mcfd_front_filter #(
		.CHANNELS     (CHANNELS),
		.FILTER_DEPTH (FILTER_DEPTH)
	) u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.write   (adv_s1 && status.done),
		.channel (channel_s1),
		.front   (status.payload[PL_FLAGS][FLAG_FRONT]),
		.all_set (front_all)
	);

	// Goal direction and distance go to the colour named by the flag bit;
	// the other colour reads zero.
	assign yellow = status.payload[PL_FLAGS][FLAG_YELLOW];

	always_comb begin
		result        = '0;
		result[7:0]   = status.payload[PL_BALL_DIR];
		result[15:8]  = status.payload[PL_BALL_DIST];
		result[23:16] = status.payload[PL_WALL];
		result[31:24] = status.payload[PL_PROX];
		result[39:32] = yellow ? status.payload[PL_GOAL_DIR]  : 8'h00;
		result[47:40] = yellow ? status.payload[PL_GOAL_DIST] : 8'h00;
		result[55:48] = yellow ? 8'h00 : status.payload[PL_GOAL_DIR];
		result[63:56] = yellow ? 8'h00 : status.payload[PL_GOAL_DIST];
		result[64]    = front_all;
		// Scaling the heading to degrees and back is the identity.
		result[72:65] = heading_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && status.done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && status.done) begin
			out_data_q <= result;
			out_chan_q <= channel_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_chan_q;

	// A held input word keeps its channel until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(channel_s1))
		else $error("input register changed while held");

	// A new result only appears after a completed frame left the input register.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && status.done))
		else $error("result without a completed frame");

	// A completed frame always belongs to a channel that exists.
	a_done_chan: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (32'(channel_s1) < 32'(CHANNELS)) && valid_s1)
		else $error("frame completed on a missing channel");

	// The payload of a frame is reported with the channel it was collected on.
	a_out_chan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> out_chan_q == $past(channel_s1))
		else $error("result carries the wrong channel");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the multi-channel frame deframer core.
`timescale 1ns / 100ps

module testbench;
	import mcfd_pkg::*;

	localparam int CHANNELS     = 4;
	localparam int FILTER_DEPTH = 10;
	localparam int SEQ_MAX      = 9;

	// Idling regimes that the driver and the receiver model follow.
	typedef enum logic [2:0] {
		PH_STEADY,
		PH_SENDER_GAPS,
		PH_RECEIVER_STALLS,
		PH_BOTH_IDLE,
		PH_BACKPRESSURE
	} idle_phase_t;

	// One byte as it travels on the slave stream.
	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [BYTE_W-1:0] rx;
		logic [BYTE_W-1:0] heading;
	} rx_word_t;

	// One decoded frame as it travels on the master stream.
	typedef struct packed {
		logic [CHAN_W-1:0] frame_channel;
		logic [BYTE_W-1:0] ball_direction;
		logic [BYTE_W-1:0] ball_distance;
		logic [BYTE_W-1:0] wall_distance;
		logic [BYTE_W-1:0] proximity_value;
		logic [BYTE_W-1:0] yellow_direction;
		logic [BYTE_W-1:0] yellow_distance;
		logic [BYTE_W-1:0] blue_direction;
		logic [BYTE_W-1:0] blue_distance;
		logic              front_filtered;
		logic [BYTE_W-1:0] reply_byte;
	} frame_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [7:0] rx_byte, [15:8] heading_byte
	logic [1:0]  s_tuser  = '0;   // [1:0] channel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;         // decoded frame fields, ball_direction at the bottom
	logic [1:0]  m_tuser;         // [1:0] frame_channel

	multi_channel_frame_deframer_core #(
		.CHANNELS    (CHANNELS),
		.FILTER_DEPTH(FILTER_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Free-running 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Words waiting to be offered, and frames the deframer owes us.
	rx_word_t      pending_words [$];
	frame_result_t expected_frames [$];

	idle_phase_t phase = PH_STEADY;
	logic        word_taken = 1'b0;
	int          fault_count = 0;

	// Receiver hold-off bookkeeping, owned by the receiver process.
	int   stall_left = 0;
	logic long_stall_done = 1'b0;

	// Our own copy of the per-channel framer, payload store and goal-front ring.
	logic [POS_W-1:0]        frame_pos     [CHANNELS];
	logic [BYTE_W-1:0]       payload_bytes [CHANNELS][PAYLOAD_LEN];
	logic [FILTER_DEPTH-1:0] front_ring    [CHANNELS];
	int                      ring_ptr      [CHANNELS];

	// Per-channel byte sequences that the random generator hands out in order.
	logic [BYTE_W-1:0] seq_buf [CHANNELS][SEQ_MAX];
	int                seq_len [CHANNELS];
	int                seq_idx [CHANNELS];

	task automatic clear_deframer_model();
		for (int c = 0; c < CHANNELS; c++) begin
			frame_pos[c]  = POS_HUNT;
			front_ring[c] = '0;
			ring_ptr[c]   = 0;
			seq_len[c]    = 0;
			seq_idx[c]    = 0;
		end
	endtask

	// Advances the framer of one channel by one byte. A good footer queues the frame
	// that the deframer has to emit for it.
	task automatic deframe_word(input rx_word_t w);
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] flags;
		logic              yellow;
		frame_result_t     r;
		int                c;
		c = w.chan;
		if (c < CHANNELS) begin
			pos = frame_pos[c];
			if (pos == POS_HUNT) begin
				// Only the header byte opens a frame.
				if (w.rx == HDR_BYTE)
					frame_pos[c] = POS_HUNT + 4'd1;
			end else if (pos <= POS_LAST) begin
				// Payload slots take any byte, the header value included.
				payload_bytes[c][pos - 4'd1] = w.rx;
				frame_pos[c] = pos + 4'd1;
			end else begin
				// Footer slot: hunting resumes whatever this byte is, and it is never
				// looked at as a new header.
				frame_pos[c] = POS_HUNT;
				if (w.rx == FTR_BYTE) begin
					flags  = payload_bytes[c][PL_FLAGS];
					yellow = flags[FLAG_YELLOW];
					front_ring[c][ring_ptr[c]] = flags[FLAG_FRONT];
					ring_ptr[c] = (ring_ptr[c] + 1 >= FILTER_DEPTH) ? 0 : ring_ptr[c] + 1;
					r.frame_channel    = w.chan;
					r.ball_direction   = payload_bytes[c][PL_BALL_DIR];
					r.ball_distance    = payload_bytes[c][PL_BALL_DIST];
					r.wall_distance    = payload_bytes[c][PL_WALL];
					r.proximity_value  = payload_bytes[c][PL_PROX];
					r.yellow_direction = yellow ? payload_bytes[c][PL_GOAL_DIR] : '0;
					r.yellow_distance  = yellow ? payload_bytes[c][PL_GOAL_DIST] : '0;
					r.blue_direction   = yellow ? '0 : payload_bytes[c][PL_GOAL_DIR];
					r.blue_distance    = yellow ? '0 : payload_bytes[c][PL_GOAL_DIST];
					r.front_filtered   = &front_ring[c];
					r.reply_byte       = w.heading;
					expected_frames.push_back(r);
				end
			end
		end
	endtask

	task automatic push_word(input int chan, input int rx, input int heading);
		rx_word_t w;
		w.chan    = chan[CHAN_W-1:0];
		w.rx      = rx[BYTE_W-1:0];
		w.heading = heading[BYTE_W-1:0];
		pending_words.push_back(w);
	endtask

	// Plans the next stretch of bytes for one channel. Most of it is well-formed
	// frames with random payload; the rest is bad footers, stray bytes while hunting
	// and frames cut short before their footer.
	task automatic plan_sequence(input int c);
		int kind;
		int footer;
		kind = $urandom_range(0, 99);
		seq_idx[c] = 0;
		if (kind >= 88 && kind < 95) begin
			seq_buf[c][0] = BYTE_W'($urandom_range(0, 254));
			seq_len[c] = 1;
		end else begin
			seq_buf[c][0] = HDR_BYTE;
			for (int k = 1; k <= PAYLOAD_LEN; k++) begin
				// Every so often a payload byte sits at one of its extremes.
				if ($urandom_range(0, 7) == 0)
					seq_buf[c][k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					seq_buf[c][k] = BYTE_W'($urandom_range(0, 255));
			end
			// Goal in front most of the time, so the all-of-ring filter gets to fire.
			seq_buf[c][1 + PL_FLAGS][FLAG_FRONT] = ($urandom_range(0, 99) < 95);
			seq_len[c] = SEQ_MAX;
			if (kind < 78) begin
				seq_buf[c][SEQ_MAX-1] = FTR_BYTE;
			end else if (kind < 88) begin
				footer = $urandom_range(0, 254);
				if (footer >= FTR_BYTE)
					footer++;
				seq_buf[c][SEQ_MAX-1] = BYTE_W'(footer);
			end else begin
				seq_len[c] = $urandom_range(2, 7);
			end
		end
	endtask

	task automatic push_random_word();
		int c;
		c = $urandom_range(0, CHANNELS - 1);
		if (seq_idx[c] >= seq_len[c])
			plan_sequence(c);
		push_word(c, seq_buf[c][seq_idx[c]], $urandom_range(0, 255));
		seq_idx[c]++;
	endtask

	// Runs one idling regime over a batch of random words and lets it drain.
	task automatic run_phase(input idle_phase_t ph, input int count);
		phase = ph;
		for (int n = 0; n < count; n++)
			push_random_word();
		while (pending_words.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	function automatic logic sender_idles(input idle_phase_t ph);
		case (ph)
			PH_SENDER_GAPS: return $urandom_range(0, 99) < 73;
			PH_BOTH_IDLE:   return $urandom_range(0, 99) < 11;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stalls(input idle_phase_t ph);
		case (ph)
			PH_RECEIVER_STALLS: return $urandom_range(0, 99) < 73;
			PH_BOTH_IDLE:       return $urandom_range(0, 99) < 11;
			default:            return 1'b0;
		endcase
	endfunction

	task automatic flag_mismatch(input string field, input int exp_val, input int got_val);
		$error("%s: expected %0d, got %0d", field, exp_val, got_val);
		fault_count++;
	endtask

	// Driver. A word stays on the bus until the edge that takes it; only then does
	// the next one go up, possibly after the sender idles.
	always @(negedge clk) begin
		rx_word_t w;
		logic     offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			offer = pending_words.size() != 0 && !sender_idles(phase);
			if (offer) begin
				w = pending_words.pop_front();
				s_tuser <= w.chan;
				s_tdata <= {w.heading, w.rx};
			end
			s_tvalid <= offer;
		end
	end

	// Receiver. In the backpressure regime it holds off once for a long stretch while
	// the driver keeps offering, so the output register fills and s_tready drops.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (phase == PH_BACKPRESSURE && !long_stall_done) begin
			m_tready        <= 1'b0;
			stall_left      <= 300;
			long_stall_done <= 1'b1;
		end else begin
			m_tready <= !receiver_stalls(phase);
		end
	end

	// Monitor. Accepted input words advance the framer copy; accepted output words
	// are compared with the oldest frame still owed.
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		word_taken <= s_tvalid && s_tready && arst_n;
		if (arst_n && s_tvalid && s_tready)
			deframe_word('{chan: s_tuser, rx: s_tdata[7:0], heading: s_tdata[15:8]});
		if (arst_n && m_tvalid && m_tready) begin
			got.frame_channel    = m_tuser;
			got.ball_direction   = m_tdata[7:0];
			got.ball_distance    = m_tdata[15:8];
			got.wall_distance    = m_tdata[23:16];
			got.proximity_value  = m_tdata[31:24];
			got.yellow_direction = m_tdata[39:32];
			got.yellow_distance  = m_tdata[47:40];
			got.blue_direction   = m_tdata[55:48];
			got.blue_distance    = m_tdata[63:56];
			got.front_filtered   = m_tdata[64];
			got.reply_byte       = m_tdata[72:65];
			if (expected_frames.size() == 0) begin
				$error("frame on channel %0d with none expected", got.frame_channel);
				fault_count++;
			end else begin
				want = expected_frames.pop_front();
				if (got.frame_channel !== want.frame_channel)
					flag_mismatch("frame_channel", want.frame_channel, got.frame_channel);
				if (got.ball_direction !== want.ball_direction)
					flag_mismatch("ball_direction", want.ball_direction, got.ball_direction);
				if (got.ball_distance !== want.ball_distance)
					flag_mismatch("ball_distance", want.ball_distance, got.ball_distance);
				if (got.wall_distance !== want.wall_distance)
					flag_mismatch("wall_distance", want.wall_distance, got.wall_distance);
				if (got.proximity_value !== want.proximity_value)
					flag_mismatch("proximity_value", want.proximity_value,
						got.proximity_value);
				if (got.yellow_direction !== want.yellow_direction)
					flag_mismatch("yellow_direction", want.yellow_direction,
						got.yellow_direction);
				if (got.yellow_distance !== want.yellow_distance)
					flag_mismatch("yellow_distance", want.yellow_distance,
						got.yellow_distance);
				if (got.blue_direction !== want.blue_direction)
					flag_mismatch("blue_direction", want.blue_direction, got.blue_direction);
				if (got.blue_distance !== want.blue_distance)
					flag_mismatch("blue_distance", want.blue_distance, got.blue_distance);
				if (got.front_filtered !== want.front_filtered)
					flag_mismatch("front_filtered", want.front_filtered, got.front_filtered);
				if (got.reply_byte !== want.reply_byte)
					flag_mismatch("reply_byte", want.reply_byte, got.reply_byte);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int n;
		clear_deframer_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Channel 1 gets a frame made of header bytes only, with the flags byte at
		// all ones (yellow goal, goal in front); channel 3 sees stray bytes,
		// the footer value among them, while it hunts.
		push_word(1, HDR_BYTE, 8'h00);
		push_word(3, 8'h00, 8'hFF);
		for (n = 0; n < PAYLOAD_LEN; n++)
			push_word(1, HDR_BYTE, n * 37);
		push_word(3, FTR_BYTE, 8'h55);
		push_word(1, FTR_BYTE, 8'h00);
		// Channel 2 gets an all-zero frame whose footer is the header value. That
		// byte must drop the frame without opening a new one, so the next byte is
		// ignored rather than stored.
		push_word(2, HDR_BYTE, 8'hFF);
		for (n = 0; n < PAYLOAD_LEN; n++)
			push_word(2, 8'h00, 8'hFF);
		push_word(2, HDR_BYTE, 8'h00);
		push_word(2, 8'h01, 8'hAA);

		run_phase(PH_STEADY, 300);
		run_phase(PH_SENDER_GAPS, 400);
		run_phase(PH_RECEIVER_STALLS, 400);
		run_phase(PH_BOTH_IDLE, 400);
		run_phase(PH_BACKPRESSURE, 300);

		// Drain: wait until no frame is owed any more, then allow a short grace period.
		for (n = 0; n < 1000 && expected_frames.size() != 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_frames.size() != 0) begin
			$error("%0d expected frames never arrived", expected_frames.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("** multi_channel_frame_deframer_core: PASSED **");
		else
			$display("** multi_channel_frame_deframer_core: FAILED **");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("** multi_channel_frame_deframer_core: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mcfd_pkg.sv
src/mcfd_framer.sv
src/mcfd_front_filter.sv
src/multi_channel_frame_deframer_core.sv
tb/testbench.sv
